FILE: rtl/core/dtsp_pkg.sv
// Shared constants, types and helper functions of the device tree structure parser.
package dtsp_pkg;

	localparam int ADDR_BITS = 20;
	localparam int WIDX_BITS = ADDR_BITS - 2;
	localparam int WORD_BITS = 32;

	localparam logic [WORD_BITS-1:0] FDT_MAGIC      = 32'hD00D_FEED;
	localparam logic [WORD_BITS-1:0] TOK_BEGIN_NODE = 32'd1;
	localparam logic [WORD_BITS-1:0] TOK_END_NODE   = 32'd2;
	localparam logic [WORD_BITS-1:0] TOK_PROP       = 32'd3;
	localparam logic [WORD_BITS-1:0] TOK_NOP        = 32'd4;
	localparam logic [WORD_BITS-1:0] TOK_END        = 32'd9;

	localparam int HDR_STRUCT_IDX  = 2;
	localparam int HDR_STRINGS_IDX = 3;

	typedef enum logic [1:0] {
		EV_PROP      = 2'd0,
		EV_END       = 2'd1,
		EV_BAD_MAGIC = 2'd2,
		EV_BAD_TOKEN = 2'd3
	} event_t;

	typedef struct packed {
		logic                 valid;
		event_t               ev;
		logic [ADDR_BITS-1:0] node_name_offset;
		logic [ADDR_BITS-1:0] prop_name_offset;
		logic [ADDR_BITS-1:0] value_offset;
		logic [ADDR_BITS-1:0] value_length;
	} result_t;

	// Clamp a widened value to the byte address range.
	function automatic logic [ADDR_BITS-1:0] sat_addr(input logic [WORD_BITS:0] x);
		logic [ADDR_BITS-1:0] r;
		if (|x[WORD_BITS:ADDR_BITS]) begin
			r = {ADDR_BITS{1'b1}};
		end else begin
			r = x[ADDR_BITS-1:0];
		end
		return r;
	endfunction

	// Clamp a widened value to the word index range.
	function automatic logic [WIDX_BITS-1:0] sat_widx(input logic [WORD_BITS:0] x);
		logic [WIDX_BITS-1:0] r;
		if (|x[WORD_BITS:WIDX_BITS]) begin
			r = {WIDX_BITS{1'b1}};
		end else begin
			r = x[WIDX_BITS-1:0];
		end
		return r;
	endfunction

	// Byte offset of the word after index w, saturated.
	function automatic logic [ADDR_BITS-1:0] next_word_addr(input logic [WIDX_BITS-1:0] w);
		logic [WIDX_BITS:0]   n;
		logic [ADDR_BITS-1:0] r;
		n = {1'b0, w} + {{WIDX_BITS{1'b0}}, 1'b1};
		if (n[WIDX_BITS]) begin
			r = {ADDR_BITS{1'b1}};
		end else begin
			r = {n[WIDX_BITS-1:0], 2'b00};
		end
		return r;
	endfunction

	function automatic logic has_zero_byte(input logic [WORD_BITS-1:0] w);
		return (w[7:0] == 8'h00) || (w[15:8] == 8'h00) ||
			(w[23:16] == 8'h00) || (w[31:24] == 8'h00);
	endfunction

endpackage

FILE: rtl/core/dtsp_walker.sv
// Parse state and one-word step logic of the device tree structure walker.
module dtsp_walker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic                               restart,
	input  logic [dtsp_pkg::WORD_BITS-1:0]     word,
	output dtsp_pkg::result_t                  res
);

	typedef enum logic [7:0] {
		PH_MAGIC  = 8'b0000_0001,
		PH_HEADER = 8'b0000_0010,
		PH_TOKEN  = 8'b0000_0100,
		PH_NAME   = 8'b0000_1000,
		PH_PLEN   = 8'b0001_0000,
		PH_PNAME  = 8'b0010_0000,
		PH_SKIP   = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	localparam int AB = dtsp_pkg::ADDR_BITS;
	localparam int WB = dtsp_pkg::WIDX_BITS;
	localparam int DB = dtsp_pkg::WORD_BITS;

	phase_t         phase_q, phase_c, phase_d;
	logic [WB-1:0]  widx_q, widx_c, widx_d;
	logic [AB-1:0]  struct_q, struct_c, struct_d, struct_eff;
	logic [AB-1:0]  strings_q, strings_c, strings_d;
	logic [AB-1:0]  node_q, node_c, node_d;
	logic [AB-1:0]  plen_q, plen_c, plen_d;
	logic [WB-1:0]  skip_q, skip_c, skip_d;
	logic [DB:0]    word_ext;

	assign word_ext = {1'b0, word};

	always_comb begin
		// restart clears the parse before this word is taken
		phase_c   = restart ? PH_MAGIC : phase_q;
		widx_c    = restart ? '0 : widx_q;
		struct_c  = restart ? '0 : struct_q;
		strings_c = restart ? '0 : strings_q;
		node_c    = restart ? '0 : node_q;
		plen_c    = restart ? '0 : plen_q;
		skip_c    = restart ? '0 : skip_q;

		phase_d    = phase_c;
		widx_d     = (&widx_c) ? widx_c : widx_c + {{(WB-1){1'b0}}, 1'b1};
		struct_d   = struct_c;
		strings_d  = strings_c;
		node_d     = node_c;
		plen_d     = plen_c;
		skip_d     = skip_c;
		struct_eff = struct_c;

		res                  = '0;
		res.ev               = dtsp_pkg::EV_PROP;
		res.node_name_offset = node_c;

		unique case (phase_c)
			PH_MAGIC: begin
				if (word != dtsp_pkg::FDT_MAGIC) begin
					phase_d   = PH_DONE;
					res.valid = 1'b1;
					res.ev    = dtsp_pkg::EV_BAD_MAGIC;
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (widx_c == WB'(dtsp_pkg::HDR_STRUCT_IDX)) begin
					struct_eff = dtsp_pkg::sat_addr(word_ext);
				end
				struct_d = struct_eff;
				if (widx_c == WB'(dtsp_pkg::HDR_STRINGS_IDX)) begin
					strings_d = dtsp_pkg::sat_addr(word_ext);
				end
				// enter the token walk at the word the struct offset points to, but no earlier than word 4
				if (widx_c >= WB'(dtsp_pkg::HDR_STRINGS_IDX) &&
					({1'b0, widx_c} + {{WB{1'b0}}, 1'b1}) >=
					{1'b0, struct_eff[AB-1:2]}) begin
					phase_d = PH_TOKEN;
				end
			end
			PH_TOKEN: begin
				unique case (word) inside
					dtsp_pkg::TOK_BEGIN_NODE: begin
						node_d  = dtsp_pkg::next_word_addr(widx_c);
						phase_d = PH_NAME;
					end
					dtsp_pkg::TOK_PROP: begin
						phase_d = PH_PLEN;
					end
					dtsp_pkg::TOK_END: begin
						phase_d   = PH_DONE;
						res.valid = 1'b1;
						res.ev    = dtsp_pkg::EV_END;
					end
					dtsp_pkg::TOK_END_NODE, dtsp_pkg::TOK_NOP: begin
						phase_d = PH_TOKEN;
					end
					default: begin
						phase_d   = PH_DONE;
						res.valid = 1'b1;
						res.ev    = dtsp_pkg::EV_BAD_TOKEN;
					end
				endcase
			end
			PH_NAME: begin
				if (dtsp_pkg::has_zero_byte(word)) begin
					phase_d = PH_TOKEN;
				end
			end
			PH_PLEN: begin
				plen_d  = dtsp_pkg::sat_addr(word_ext);
				skip_d  = dtsp_pkg::sat_widx((word_ext + (DB+1)'(3)) >> 2);
				phase_d = PH_PNAME;
			end
			PH_PNAME: begin
				res.valid            = 1'b1;
				res.ev               = dtsp_pkg::EV_PROP;
				res.prop_name_offset = dtsp_pkg::sat_addr(
					{{(DB+1-AB){1'b0}}, strings_c} + word_ext);
				res.value_offset     = dtsp_pkg::next_word_addr(widx_c);
				res.value_length     = plen_c;
				phase_d              = (skip_c == '0) ? PH_TOKEN : PH_SKIP;
			end
			PH_SKIP: begin
				if (skip_c != '0) begin
					skip_d = skip_c - {{(WB-1){1'b0}}, 1'b1};
				end
				if (skip_c <= {{(WB-1){1'b0}}, 1'b1}) begin
					phase_d = PH_TOKEN;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC;
			widx_q    <= '0;
			struct_q  <= '0;
			strings_q <= '0;
			node_q    <= '0;
			plen_q    <= '0;
			skip_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			widx_q    <= widx_d;
			struct_q  <= struct_d;
			strings_q <= strings_d;
			node_q    <= node_d;
			plen_q    <= plen_d;
			skip_q    <= skip_d;
		end
	end

endmodule

FILE: rtl/core/device_tree_struct_parser_unit.sv
// Device tree structure parser: blob word stream in, property and status events out.
//
// Usage: feed the blob as big-endian 32-bit words from offset 0 on the s_ group,
// one word per beat, with s_tuser set on the word at offset 0 to restart a parse.
// Each property in the structure block yields one m_ beat carrying the node name
// offset, property name offset, value offset and value length; end of tree, bad
// magic and unknown token also yield one beat each, after which words are
// dropped until the next restart.
// Flow: a word accepted into the input register is parsed as it advances, and
// its event is then shown on m_ from the output register. Throughput: one word
// per cycle while the receiver does not stall, set by the parse step between the
// input and output registers; the parse state advances once per word.
// Reset: arst_n clears the parse to expect the header magic and empties both
// registers. When the receiver stalls, the pending event is held, one more word
// waits in the input register, and s_tready drops until the event is taken.
module device_tree_struct_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] blob_word
	input  logic [0:0]  s_tuser,   // [0] first_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [19:0] node_name_offset, [39:20] prop_name_offset,
	                               // [59:40] value_offset, [79:60] value_length
	output logic [1:0]  m_tuser    // [1:0] event_res
);

	logic                          valid_s1;
	logic [dtsp_pkg::WORD_BITS-1:0] word_s1;
	logic                          first_s1;
	logic                          advance;
	dtsp_pkg::result_t             res;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1  <= s_tdata;
			first_s1 <= s_tuser[0];
		end
	end

	dtsp_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.restart (first_s1),
		.word    (word_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= advance && res.valid;
		end
	end

	// load the output beat only when an event is produced
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			m_tuser <= res.ev;
			m_tdata <= {res.value_length, res.value_offset,
				res.prop_name_offset, res.node_name_offset};
		end
	end

`ifndef NO_ASSERTIONS
	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(word_s1) && $stable(first_s1)))
		else $error("stalled input word lost or changed");

	a_status_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != dtsp_pkg::EV_PROP) |->
		(m_tdata[79:20] == 60'd0))
		else $error("status event carries property fields");

	a_bad_magic_no_node: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == dtsp_pkg::EV_BAD_MAGIC) |-> (m_tdata[19:0] == 20'd0))
		else $error("bad magic event with node offset");
`endif

endmodule

FILE: tb/dtsp_tb_pkg.sv
// Scoreboard and parse predictor for the device tree structure parser testbench.
`timescale 1ns / 1ps
package dtsp_tb_pkg;
	import dtsp_pkg::*;

	typedef enum int {
		WAIT_MAGIC,
		READ_HEADER,
		WAIT_TOKEN,
		IN_NAME,
		PROP_LENGTH,
		PROP_NAMEOFF,
		IN_VALUE,
		STOPPED
	} walk_phase_t;

	typedef struct {
		event_t               ev;
		logic [ADDR_BITS-1:0] node_name;
		logic [ADDR_BITS-1:0] prop_name;
		logic [ADDR_BITS-1:0] value_off;
		logic [ADDR_BITS-1:0] value_len;
	} fdt_event_t;

	localparam longint unsigned ADDR_MAX = (64'd1 << ADDR_BITS) - 1;
	localparam longint unsigned WIDX_MAX = (64'd1 << WIDX_BITS) - 1;

	class fdt_scoreboard;
		walk_phase_t     phase;
		longint unsigned widx;
		longint unsigned struct_base;
		longint unsigned strings_base;
		longint unsigned node_name;
		longint unsigned prop_len;
		longint unsigned words_left;
		fdt_event_t      pending_events[$];
		int              errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase        = WAIT_MAGIC;
			widx         = 0;
			struct_base  = 0;
			strings_base = 0;
			node_name    = 0;
			prop_len     = 0;
			words_left   = 0;
		endfunction

		function longint unsigned clamp_addr(longint unsigned x);
			return (x > ADDR_MAX) ? ADDR_MAX : x;
		endfunction

		function longint unsigned clamp_idx(longint unsigned x);
			return (x > WIDX_MAX) ? WIDX_MAX : x;
		endfunction

		function bit name_ends(logic [31:0] word);
			bit found;
			found = 1'b0;
			for (int b = 0; b < 4; b++) begin
				if (word[8*b +: 8] == 8'h00)
					found = 1'b1;
			end
			return found;
		endfunction

		function void queue_event(event_t ev, longint unsigned pn, longint unsigned vo,
				longint unsigned vl);
			fdt_event_t e;
			e.ev        = ev;
			e.node_name = node_name[ADDR_BITS-1:0];
			e.prop_name = pn[ADDR_BITS-1:0];
			e.value_off = vo[ADDR_BITS-1:0];
			e.value_len = vl[ADDR_BITS-1:0];
			pending_events.push_back(e);
		endfunction

		// Advance the walk by one accepted word; return 1 unless the word is dropped.
		function bit note_word(logic [31:0] word, bit first);
			longint unsigned w;
			longint unsigned wv;
			bit              live;
			if (first)
				restart();
			live = (phase != STOPPED);
			wv   = word;
			w    = widx;
			widx = clamp_idx(widx + 1);
			case (phase)
				WAIT_MAGIC: begin
					if (word != FDT_MAGIC) begin
						phase = STOPPED;
						queue_event(EV_BAD_MAGIC, 0, 0, 0);
					end else begin
						phase = READ_HEADER;
					end
				end
				READ_HEADER: begin
					if (w == HDR_STRUCT_IDX)
						struct_base = clamp_addr(wv);
					if (w == HDR_STRINGS_IDX)
						strings_base = clamp_addr(wv);
					if (w >= HDR_STRINGS_IDX && w + 1 >= (struct_base >> 2))
						phase = WAIT_TOKEN;
				end
				WAIT_TOKEN: begin
					if (word == TOK_BEGIN_NODE) begin
						node_name = clamp_addr((w + 1) * 4);
						phase     = IN_NAME;
					end else if (word == TOK_PROP) begin
						phase = PROP_LENGTH;
					end else if (word == TOK_END) begin
						phase = STOPPED;
						queue_event(EV_END, 0, 0, 0);
					end else if (word != TOK_END_NODE && word != TOK_NOP) begin
						phase = STOPPED;
						queue_event(EV_BAD_TOKEN, 0, 0, 0);
					end
				end
				IN_NAME: begin
					if (name_ends(word))
						phase = WAIT_TOKEN;
				end
				PROP_LENGTH: begin
					prop_len   = clamp_addr(wv);
					words_left = clamp_idx((wv + 3) >> 2);
					phase      = PROP_NAMEOFF;
				end
				PROP_NAMEOFF: begin
					phase = (words_left == 0) ? WAIT_TOKEN : IN_VALUE;
					queue_event(EV_PROP, clamp_addr(strings_base + wv),
						clamp_addr((w + 1) * 4), prop_len);
				end
				IN_VALUE: begin
					if (words_left > 0)
						words_left--;
					if (words_left == 0)
						phase = WAIT_TOKEN;
				end
				default: begin
				end
			endcase
			return live;
		endfunction

		function void compare_field(string what, logic [ADDR_BITS-1:0] want,
				logic [ADDR_BITS-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t tb: %s mismatch, expected %h, actual %h", $time, what, want, got);
			end
		endfunction

		// Match one output beat against the oldest predicted event.
		function void check_event(logic [1:0] ev_bits, logic [79:0] data);
			fdt_event_t want;
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t tb: event %0d with nothing predicted, expected none, actual %h",
					$time, ev_bits, data);
				return;
			end
			want = pending_events.pop_front();
			compare_field("event", {{(ADDR_BITS-2){1'b0}}, want.ev},
				{{(ADDR_BITS-2){1'b0}}, ev_bits});
			compare_field("node_name_offset", want.node_name, data[ADDR_BITS-1:0]);
			compare_field("prop_name_offset", want.prop_name, data[2*ADDR_BITS-1:ADDR_BITS]);
			compare_field("value_offset", want.value_off, data[3*ADDR_BITS-1:2*ADDR_BITS]);
			compare_field("value_length", want.value_len, data[4*ADDR_BITS-1:3*ADDR_BITS]);
		endfunction
	endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench of the device tree structure parser: blob stimulus and checking.
`timescale 1ns / 1ps
module tb;
	import dtsp_pkg::*;
	import dtsp_tb_pkg::*;

	localparam int ITEM_TARGET = 1100;
	localparam int CALM_AFTER  = 900;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	fdt_scoreboard sb;
	logic [31:0]   blob[$];
	int            live_items = 0;
	bit            calm = 1'b0;

	device_tree_struct_parser_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// Receiver: ready runs broken by stall bursts, none once the run is calm.
	initial begin : sink_ready
		int n;
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			n = $urandom_range(1, 40);
			repeat (n) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_event(m_tuser, m_tdata);
	end

	task automatic send_word(input logic [31:0] word, input bit first, input bit gaps);
		if (gaps && !calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (sb.note_word(word, first))
			live_items++;
	endtask

	task automatic send_blob(input bit mark_first, input bit gaps);
		int i;
		for (i = 0; i < blob.size(); i++)
			send_word(blob[i], mark_first && i == 0, gaps);
		blob.delete();
	endtask

	function automatic logic [31:0] name_chars();
		logic [31:0] w;
		for (int b = 0; b < 4; b++)
			w[8*b +: 8] = $urandom_range(1, 255);
		return w;
	endfunction

	function automatic logic [31:0] unknown_token();
		return $urandom_range(0, 1) ? 32'($urandom_range(5, 8)) : ($urandom | 32'h10);
	endfunction

	task automatic add_header(input int unsigned struct_off, input logic [31:0] strings_off);
		int unsigned i;
		blob.push_back(FDT_MAGIC);
		blob.push_back($urandom);
		blob.push_back(struct_off);
		blob.push_back(strings_off);
		// pad up to the word holding the struct offset
		for (i = 4; i < struct_off / 4; i++)
			blob.push_back($urandom);
	endtask

	task automatic add_name();
		int          n, i;
		logic [31:0] last;
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++)
			blob.push_back(name_chars());
		last = name_chars();
		last[8*$urandom_range(0, 3) +: 8] = 8'h00;
		if ($urandom_range(0, 3) == 0)
			last[8*$urandom_range(0, 3) +: 8] = 8'h00;
		blob.push_back(last);
	endtask

	task automatic add_prop(input logic [31:0] len, input logic [31:0] nameoff,
			input bit with_value);
		int unsigned i;
		blob.push_back(TOK_PROP);
		blob.push_back(len);
		blob.push_back(nameoff);
		if (with_value) begin
			for (i = 0; i < (len + 3) / 4; i++)
				blob.push_back($urandom);
		end
	endtask

	task automatic build_tree();
		int unsigned struct_off;
		logic [31:0] strings_off;
		logic [31:0] len;
		logic [31:0] nameoff;
		int          n_tok, t, r, i;
		bit          cut;
		cut = 1'b0;
		case ($urandom_range(0, 9))
			0: struct_off = $urandom_range(0, 15);
			1: struct_off = 40 + $urandom_range(1, 3);
			2: struct_off = $urandom_range(16, 200);
			default: struct_off = 40;
		endcase
		strings_off = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4096);
		add_header(struct_off, strings_off);
		n_tok = $urandom_range(1, 16);
		for (t = 0; t < n_tok && !cut; t++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					blob.push_back(TOK_BEGIN_NODE);
					add_name();
				end
				2: blob.push_back(TOK_END_NODE);
				3: blob.push_back(TOK_NOP);
				default: begin
					nameoff = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 512);
					r = $urandom_range(0, 39);
					if (r < 4) begin
						len = 0;
					end else if (r == 4) begin
						// saturated length: stop here, the next blob restarts the parse
						len = $urandom | 32'h0010_0000;
						cut = 1'b1;
					end else if (r < 10) begin
						len = $urandom_range(17, 64);
					end else begin
						len = $urandom_range(1, 16);
					end
					add_prop(len, nameoff, !cut);
				end
			endcase
		end
		if (!cut) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				blob.push_back(unknown_token());
			else if (r != 1)
				blob.push_back(TOK_END);
			if ($urandom_range(0, 2) == 0) begin
				for (i = $urandom_range(1, 4); i > 0; i--)
					blob.push_back($urandom);
			end
		end
	endtask

	task automatic build_noise();
		int n, i;
		if ($urandom_range(0, 1))
			add_header($urandom_range(0, 64), $urandom);
		else
			blob.push_back(FDT_MAGIC);
		n = $urandom_range(1, 30);
		for (i = 0; i < n; i++)
			blob.push_back($urandom_range(0, 1) ? 32'($urandom_range(0, 9)) : $urandom);
	endtask

	initial begin : stimulus
		int n, i;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Parse taken up without a restart mark; struct offset inside the header,
		// saturated property name, zero-length value, every token but TOK_END, unknown token.
		add_header(8, 32'h000F_FFF0);
		add_prop(0, 32'h10, 1'b1);
		blob.push_back(TOK_BEGIN_NODE);
		blob.push_back(32'h6162_6300);
		add_prop(5, 4, 1'b1);
		blob.push_back(TOK_NOP);
		blob.push_back(TOK_END_NODE);
		blob.push_back(unknown_token());
		send_blob(1'b0, 1'b0);

		// Bad magic, then a dropped word.
		blob.push_back(32'h0000_0000);
		blob.push_back(32'hFFFF_FFFF);
		send_blob(1'b1, 1'b0);

		// Unaligned struct offset; all-ones length and name offset saturate.
		add_header(32'h15, 32'h40);
		add_prop(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_blob(1'b1, 1'b1);

		add_header(16, 0);
		blob.push_back(TOK_END);
		send_blob(1'b1, 1'b1);

		while (live_items < ITEM_TARGET) begin
			calm = (live_items >= CALM_AFTER);
			n = $urandom_range(0, 19);
			if (n < 2) begin
				blob.push_back($urandom);
				for (i = $urandom_range(0, 3); i > 0; i--)
					blob.push_back($urandom);
			end else if (n < 4) begin
				build_noise();
			end else begin
				build_tree();
			end
			send_blob(1'b1, $urandom_range(0, 3) != 0);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending_events.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
